// ----- hdl/fft_pkg.sv -----
package fft_pkg;

  localparam int POINTS = 128;
  localparam int ADDR_W = $clog2(POINTS);
  localparam int BF_W   = ADDR_W - 1;
  localparam int STG_W  = $clog2(ADDR_W);
  localparam int DATA_W = 25;
  localparam int TW_W   = 17;
  localparam int PROD_W = DATA_W + TW_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int T_W    = ACC_W - 15;
  localparam int TDATA_W = 40;

  localparam logic signed [ACC_W-1:0] ROUND_Q15 = ACC_W'(16384);
  localparam logic signed [15:0] MAX16 = 16'sd32767;
  localparam logic signed [15:0] MIN16 = -16'sd32768;

  // cosine samples over half a turn
  localparam logic signed [15:0] COS_TAB [64] = '{
    16'sd32767, 16'sd32728, 16'sd32609, 16'sd32412, 16'sd32137, 16'sd31785,
    16'sd31356, 16'sd30852, 16'sd30273, 16'sd29621, 16'sd28898, 16'sd28105,
    16'sd27245, 16'sd26319, 16'sd25329, 16'sd24279, 16'sd23170, 16'sd22005,
    16'sd20787, 16'sd19519, 16'sd18204, 16'sd16846, 16'sd15446, 16'sd14010,
    16'sd12539, 16'sd11039, 16'sd9512,  16'sd7962,  16'sd6393,  16'sd4808,
    16'sd3212,  16'sd1608,  16'sd0,     -16'sd1608, -16'sd3212, -16'sd4808,
    -16'sd6393, -16'sd7962, -16'sd9512, -16'sd11039, -16'sd12539, -16'sd14010,
    -16'sd15446, -16'sd16846, -16'sd18204, -16'sd19519, -16'sd20787,
    -16'sd22005, -16'sd23170, -16'sd24279, -16'sd25329, -16'sd26319,
    -16'sd27245, -16'sd28105, -16'sd28898, -16'sd29621, -16'sd30273,
    -16'sd30852, -16'sd31356, -16'sd31785, -16'sd32137, -16'sd32412,
    -16'sd32609, -16'sd32728
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] im;
    logic signed [DATA_W-1:0] re;
  } cplx_t;

  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] x);
    logic [ADDR_W-1:0] r;
    for (int i = 0; i < ADDR_W; i++) r[i] = x[ADDR_W-1-i];
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(input logic signed [DATA_W-1:0] v);
    if (v > DATA_W'(MAX16)) return MAX16;
    else if (v < DATA_W'(MIN16)) return MIN16;
    else return v[15:0];
  endfunction

endpackage

// ----- hdl/fft128_q15_radix2.sv -----
// 128-point radix-2 decimation-in-time FFT, Q15 complex samples.
// input stream: s_tuser selects the request (0 load sample, 1 read bin).
//   s_tdata: sample_re [15:0], sample_im [31:16], read_bin [38:32].
// output stream: one item per read request, none per load.
//   m_tdata: out_re [15:0], out_im [31:16], out_bin [38:32]; m_tuser: result_ready.
// cfg_wen/cfg_wdata write inverse_mode; it is taken when a frame's last load lands.
// a load lands at its bit-reversed address.
// the 128th load starts the transform: 7 stages x 64 butterflies on one shared
// 25x17 multiplier, each butterfly a read, four products in five steps and
// two writes through the single write port; s_tready is low for the whole
// transform.
// a read returns its item through the registered memory read and then the
// output register; values are clipped to 16 bits on the way out.
// a read holds the input until its result has been taken.
// s_tready is low while a result waits, so a stalled receiver holds the input.
// reset (rst, synchronous) empties the frame, clears the done flag and drops
// m_tvalid; the sample store and the output data are not cleared.
module fft128_q15_radix2 import fft_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,  // sample_re, sample_im, read_bin, zero pad
  input  logic               s_tuser,  // req_type
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,  // out_re, out_im, out_bin, zero pad
  output logic               m_tuser,  // result_ready
  input  logic               cfg_wen,
  input  logic               cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDOUT = 3'd1;
  localparam logic [2:0] S_BFRD  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_WA    = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;

  logic [2:0]        state;
  logic [ADDR_W-1:0] load_pos;
  logic              frame_done;
  logic              inverse_mode;
  logic              inv_run;
  logic [STG_W-1:0]  stage;
  logic [BF_W-1:0]   bf;
  logic [2:0]        step;
  logic [ADDR_W-1:0] bin_q;
  logic              done_q;

  cplx_t mem [POINTS];
  cplx_t rd_a, rd_b;
  logic [ADDR_W-1:0] raddr_a, raddr_b, waddr;
  logic              we;
  cplx_t             wdata;

  logic signed [DATA_W-1:0] op_a;
  logic signed [TW_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [T_W-1:0]    tr, tm;
  cplx_t                    b_hold;

  logic accept;
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign accept   = s_tvalid && s_tready;

  // butterfly addresses from stage and butterfly count
  logic [ADDR_W-1:0] bf_ext, hs, j_idx, a_idx, b_idx;
  assign bf_ext = ADDR_W'(bf);
  assign hs     = ADDR_W'(1) << stage;
  assign j_idx  = bf_ext & (hs - ADDR_W'(1));
  assign a_idx  = ((bf_ext >> stage) << (stage + STG_W'(1))) | j_idx;
  assign b_idx  = a_idx | hs;

  // twiddle lookup
  logic [5:0] ti, si;
  logic [ADDR_W+5:0] ti_w;
  logic signed [TW_W-1:0] wr, sn, wi;
  assign ti_w = ({6'd0, j_idx} << 6) >> stage;
  assign ti   = ti_w[5:0];
  assign si   = (ti > 6'd32) ? (ti - 6'd32) : (6'd32 - ti);
  assign wr   = TW_W'(COS_TAB[ti]);
  assign sn   = TW_W'(COS_TAB[si]);
  assign wi   = inv_run ? sn : -sn;

  // memory read addresses
  assign raddr_a = (state == S_IDLE) ? s_tdata[38:32] : a_idx;
  assign raddr_b = b_idx;

  // sample store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // shared multiplier operand select
  always_comb begin
    case (step)
      3'd0: begin op_a = rd_b.re; op_b = wr; end
      3'd1: begin op_a = rd_b.im; op_b = wi; end
      3'd2: begin op_a = rd_b.im; op_b = wr; end
      3'd3: begin op_a = rd_b.re; op_b = wi; end
      default: begin op_a = rd_b.re; op_b = wr; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // butterfly sums
  logic signed [T_W:0] sa_re, sa_im, sb_re, sb_im;
  cplx_t a_out, b_out;
  always_comb begin
    sa_re = (T_W+1)'(rd_a.re) + (T_W+1)'(tr);
    sa_im = (T_W+1)'(rd_a.im) + (T_W+1)'(tm);
    sb_re = (T_W+1)'(rd_a.re) - (T_W+1)'(tr);
    sb_im = (T_W+1)'(rd_a.im) - (T_W+1)'(tm);
    if (inv_run) begin
      a_out.re = sa_re[DATA_W-1:0];
      a_out.im = sa_im[DATA_W-1:0];
      b_out.re = sb_re[DATA_W-1:0];
      b_out.im = sb_im[DATA_W-1:0];
    end else begin
      a_out.re = DATA_W'((sa_re + (T_W+1)'(1)) >>> 1);
      a_out.im = DATA_W'((sa_im + (T_W+1)'(1)) >>> 1);
      b_out.re = DATA_W'((sb_re + (T_W+1)'(1)) >>> 1);
      b_out.im = DATA_W'((sb_im + (T_W+1)'(1)) >>> 1);
    end
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = a_idx;
    wdata = a_out;
    case (state)
      S_IDLE: begin
        we          = accept && !s_tuser;
        waddr       = bit_rev(load_pos);
        wdata.re    = DATA_W'($signed(s_tdata[15:0]));
        wdata.im    = DATA_W'($signed(s_tdata[31:16]));
      end
      S_WA: begin
        we = 1'b1;
      end
      S_WB: begin
        we    = 1'b1;
        waddr = b_idx;
        wdata = b_hold;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) inverse_mode <= 1'b0;
    else if (cfg_wen) inverse_mode <= cfg_wdata;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_pos   <= '0;
      frame_done <= 1'b0;
      m_tvalid   <= 1'b0;
      stage      <= '0;
      bf         <= '0;
      step       <= '0;
      inv_run    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              bin_q  <= s_tdata[38:32];
              done_q <= frame_done;
              state  <= S_RDOUT;
            end else begin
              frame_done <= 1'b0;
              load_pos   <= load_pos + ADDR_W'(1);
              if (load_pos == ADDR_W'(POINTS - 1)) begin
                inv_run <= inverse_mode;
                stage   <= '0;
                bf      <= '0;
                state   <= S_BFRD;
              end
            end
          end
        end
        S_RDOUT: begin
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
        S_BFRD: begin
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          step <= step + 3'd1;
          case (step)
            3'd1: acc <= ACC_W'(prod);
            3'd2: tr  <= T_W'((ACC_W'(acc) - ACC_W'(prod) + ROUND_Q15) >>> 15);
            3'd3: acc <= ACC_W'(prod);
            3'd4: begin
              tm    <= T_W'((ACC_W'(acc) + ACC_W'(prod) + ROUND_Q15) >>> 15);
              state <= S_WA;
            end
            default: acc <= acc;
          endcase
        end
        S_WA: begin
          b_hold <= b_out;
          state  <= S_WB;
        end
        S_WB: begin
          if (bf == BF_W'(POINTS/2 - 1)) begin
            bf <= '0;
            if (stage == STG_W'(ADDR_W - 1)) begin
              frame_done <= 1'b1;
              state      <= S_IDLE;
            end else begin
              stage <= stage + STG_W'(1);
              state <= S_BFRD;
            end
          end else begin
            bf    <= bf + BF_W'(1);
            state <= S_BFRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  logic signed [15:0] o_re, o_im;
  logic [ADDR_W-1:0]  o_bin;
  always_ff @(posedge clk) begin
    if (state == S_RDOUT) begin
      o_re    <= done_q ? clip16(rd_a.re) : 16'sd0;
      o_im    <= done_q ? clip16(rd_a.im) : 16'sd0;
      m_tuser <= done_q;
      o_bin   <= bin_q;
    end
  end
  assign m_tdata = {{(TDATA_W-39){1'b0}}, o_bin, o_im, o_re};

endmodule

// ----- hdl/fft_checker.sv -----
module fft_checker import fft_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [TDATA_W-1:0] s_tdata,
  input logic               s_tuser,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tuser
);

  // a waiting result is held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // no request taken while a result waits
  a_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("request accepted while result pending");

  // a read returns a result carrying its bin
  a_read: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |-> ##2 m_tvalid &&
      m_tdata[38:32] == $past(s_tdata[38:32], 2))
    else $error("read result missing or wrong bin");

  // without a finished frame the data is zero
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'd0)
    else $error("nonzero data without a transform");

endmodule

bind fft128_q15_radix2 fft_checker u_fft_checker (.*);

// ----- verif/fft128_q15_radix2_tb.sv -----
// one bin as seen on the output stream
typedef struct {
  logic [15:0] re;
  logic [15:0] im;
  logic [6:0]  bin;
  logic        ready;
} fft_bin_t;

// frame store, transform and queue of expected bins
class fft_scoreboard;
  longint      frame_re[128];
  longint      frame_im[128];
  int unsigned load_pos;
  bit          frame_done;
  bit          inverse;
  int          errors;
  fft_bin_t    expected_bins[$];

  function void clear();
    for (int i = 0; i < 128; i++) begin
      frame_re[i] = 0;
      frame_im[i] = 0;
    end
    load_pos = 0;
    frame_done = 0;
    inverse = 0;
    errors = 0;
    expected_bins.delete();
  endfunction

  function longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // in-place radix-2 stages over the bit-reversed frame
  function void transform();
    longint wr, wi, sn, tr, tm, ur, um;
    int unsigned a, b, ti, si;
    for (int unsigned hs = 1; hs < 128; hs <<= 1) begin
      for (int unsigned k = 0; k < 128; k += 2 * hs) begin
        for (int unsigned j = 0; j < hs; j++) begin
          a = k + j;
          b = a + hs;
          ti = ((j * 64) / hs) & 63;
          si = (ti > 32) ? ti - 32 : 32 - ti;
          wr = fft_pkg::COS_TAB[ti];
          sn = fft_pkg::COS_TAB[si & 63];
          wi = inverse ? sn : -sn;
          tr = (wr * frame_re[b] - wi * frame_im[b] + 16384) >>> 15;
          tm = (wr * frame_im[b] + wi * frame_re[b] + 16384) >>> 15;
          ur = frame_re[a];
          um = frame_im[a];
          if (!inverse) begin
            frame_re[a] = (ur + tr + 1) >>> 1;
            frame_im[a] = (um + tm + 1) >>> 1;
            frame_re[b] = (ur - tr + 1) >>> 1;
            frame_im[b] = (um - tm + 1) >>> 1;
          end else begin
            frame_re[a] = ur + tr;
            frame_im[a] = um + tm;
            frame_re[b] = ur - tr;
            frame_im[b] = um - tm;
          end
        end
      end
    end
    for (int i = 0; i < 128; i++) begin
      frame_re[i] = clamp16(frame_re[i]);
      frame_im[i] = clamp16(frame_im[i]);
    end
  endfunction

  // accepted request on the input stream
  function void note_request(logic is_read, logic signed [15:0] re,
                             logic signed [15:0] im, logic [6:0] bin);
    fft_bin_t e;
    logic [6:0] rev;
    if (is_read) begin
      e.bin = bin;
      e.ready = frame_done;
      e.re = frame_done ? frame_re[bin][15:0] : 16'h0;
      e.im = frame_done ? frame_im[bin][15:0] : 16'h0;
      expected_bins.push_back(e);
    end else begin
      for (int i = 0; i < 7; i++) rev[i] = load_pos[6-i];
      frame_re[rev] = longint'(re);
      frame_im[rev] = longint'(im);
      frame_done = 0;
      load_pos++;
      if (load_pos >= 128) begin
        load_pos = 0;
        transform();
        frame_done = 1;
      end
    end
  endfunction

  // accepted bin on the output stream
  function void check_result(logic [39:0] data, logic user);
    fft_bin_t e;
    if (expected_bins.size() == 0) begin
      $error("unexpected bin %0d", data[38:32]);
      errors++;
      return;
    end
    e = expected_bins.pop_front();
    if (data[15:0] !== e.re) begin
      $error("out_re expected %0h got %0h", e.re, data[15:0]);
      errors++;
    end
    if (data[31:16] !== e.im) begin
      $error("out_im expected %0h got %0h", e.im, data[31:16]);
      errors++;
    end
    if (data[38:32] !== e.bin) begin
      $error("out_bin expected %0d got %0d", e.bin, data[38:32]);
      errors++;
    end
    if (user !== e.ready) begin
      $error("result_ready expected %0b got %0b", e.ready, user);
      errors++;
    end
  endfunction
endclass

module fft128_q15_radix2_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        cfg_wen = 0;
  logic        cfg_wdata = 0;

  fft_scoreboard sb = new();
  int src_idle = 0;
  int snk_idle = 0;
  int hold_off = 0;
  int quiet_cycles = 0;

  fft128_q15_radix2 DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random stalls, long hold-off on request, checking and watchdog
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else if (!rst) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (hold_off > 0) begin
      hold_off--;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  // offer one request until accepted, with random gaps first
  task automatic send(input logic is_read, input logic [15:0] re,
                      input logic [15:0] im, input logic [6:0] bin);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= is_read;
    s_tdata <= {1'b0, bin, im, re};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_request(is_read, re, im, bin);
  endtask

  task automatic read_bin(input logic [6:0] bin);
    send(1, 16'($urandom), 16'($urandom), bin);
  endtask

  // wait out pending bins and a possible transform, then write the mode
  task automatic set_mode(input bit mode);
    s_tvalid <= 0;
    while (sb.expected_bins.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    cfg_wen <= 1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_wen <= 0;
    sb.inverse = mode;
  endtask

  function automatic logic [15:0] pick_sample(int style);
    case (style)
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'h4000;
    endcase
  endfunction

  // full frame of loads with scattered reads, then a burst of reads
  task automatic run_frame();
    int style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < 128; i++) begin
      if ($urandom_range(0, 99) < 15) read_bin(7'($urandom_range(0, 127)));
      send(0, pick_sample(style), pick_sample(style), 7'($urandom));
    end
    repeat (40) read_bin(7'($urandom_range(0, 127)));
  endtask

  initial begin
    sb.clear();
    repeat (3) @(posedge clk);
    rst <= 0;
    set_mode(0);

    // reads before any transform, extreme loads, read mid-frame
    read_bin(0);
    read_bin(127);
    read_bin(64);
    send(0, 16'h8000, 16'h7fff, 7'd0);
    send(0, 16'h7fff, 16'h8000, 7'd127);
    send(0, 16'h8000, 16'h8000, 7'd0);
    send(0, 16'h7fff, 16'h7fff, 7'd0);
    read_bin(5);
    for (int i = 4; i < 128; i++) send(0, 16'h7fff, 16'h8000, 7'($urandom));
    read_bin(0);
    read_bin(127);
    send(0, 16'h0001, 16'hffff, 7'd0);
    read_bin(3);

    // random phases over both modes and idling patterns
    for (int p = 0; p < 3; p++) begin
      set_mode(p != 1);
      src_idle = (p == 0) ? 34 : (p == 1) ? 77 : 0;
      snk_idle = (p == 0) ? 77 : (p == 1) ? 34 : 0;
      if (p == 2) hold_off = 400;
      repeat (3) run_frame();
    end

    s_tvalid <= 0;
    while (sb.expected_bins.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
